// File: src/ecgrpd_pkg.sv
// Shared constants for the ECG R-peak detector.
// Depends on nothing; imported by ecg_r_peak_detector_unit.
`default_nettype none

package ecgrpd_pkg;

  localparam int WINDOW     = 5;
  localparam int SAMPLE_W   = 12;
  localparam int SUM_W      = SAMPLE_W + $clog2(WINDOW);
  localparam int INDEX_W    = 32;
  localparam int COUNT_W    = 16;
  localparam int TOTAL_W    = 48;
  localparam int FILL_MAX   = WINDOW + 2;
  localparam int FILL_W     = $clog2(FILL_MAX + 1);
  localparam int CENTER_OFS = 1 + WINDOW / 2;

  localparam int SDATA_W    = 16;
  localparam int MDATA_W    = 2 * INDEX_W + COUNT_W + TOTAL_W;
  localparam int APB_ADDR_W = 3;

  localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET = SAMPLE_W'(1200);

  // Register index decoded from paddr[2]
  localparam logic REG_PEAK_THRESHOLD = 1'b0;

endpackage

`default_nettype wire

// File: src/ecg_r_peak_detector_unit.sv
// ECG R-peak detector: running five-sample sum, slope-sign peak test, interval stats.
// Depends on ecgrpd_pkg for widths and constants.
//
// Usage:
//   Input stream: one 12-bit converter sample per beat in s_axis_tdata[11:0].
//   Output stream: one beat per detected peak, carrying the window-centre index,
//   the interval since the previous peak, the running peak count and the running
//   interval total; tuser[0] flags that the interval is meaningful.
//   APB port: register 0 (byte address 0) is peak_threshold, 12 bits, reset 1200.
//   Write it only while the block is idle.
// Timing:
//   A sample is held in the input register; its result (if any) is loaded from
//   there into the output register, which offers it on the output stream. One
//   sample per cycle is sustained unless a result is blocked downstream: the
//   running sum is updated incrementally (add newest, drop oldest), so a single
//   add/subtract and three compares set the path between the input and result
//   registers.
// Reset (rst, synchronous): clears the window, sums, counters and totals, empties
//   both registers and loads the threshold with 1200. No test is made until
//   seven samples have arrived.
// Stall: while m_axis_tready is low a pending result holds; samples that cause
//   no result still drain, and s_axis_tready drops only when a new result would
//   have to overwrite the held one.
`default_nettype none

module ecg_r_peak_detector_unit
  import ecgrpd_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  // APB configuration
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [31:0]           pwdata,
  output      logic [31:0]           prdata,
  output      logic                  pready,
  // sample stream
  input  wire logic                  s_axis_tvalid,
  output      logic                  s_axis_tready,
  input  wire logic [SDATA_W-1:0]    s_axis_tdata,   // [11:0] sample
  // peak stream
  output      logic                  m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output      logic [MDATA_W-1:0]    m_axis_tdata,   // [31:0] peak_index, [63:32] interval,
                                                      // [79:64] peak_count,
                                                      // [127:80] interval_total
  output      logic                  m_axis_tuser    // [0] interval_valid
);

  // ---------------------------------------------------------------- config
  logic [SAMPLE_W-1:0] peak_threshold;
  logic                cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      peak_threshold <= THRESHOLD_RESET;
    end else if (cfg_write && paddr[2] == REG_PEAK_THRESHOLD) begin
      peak_threshold <= pwdata[SAMPLE_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_PEAK_THRESHOLD) begin
      prdata = {{(32-SAMPLE_W){1'b0}}, peak_threshold};
    end
  end

  // ---------------------------------------------------------- input register
  logic                in_valid;
  logic [SAMPLE_W-1:0] in_sample;
  logic                advance;
  logic                hit;
  logic                out_valid;

  // Move the held sample on unless it makes a result that cannot be placed.
  assign advance       = in_valid && (!out_valid || m_axis_tready || !hit);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_sample <= s_axis_tdata[SAMPLE_W-1:0];
    end
  end

  // ---------------------------------------------------------- detector state
  logic [SAMPLE_W-1:0] taps [WINDOW];   // taps[0] newest, taps[WINDOW-1] oldest
  logic [SUM_W-1:0]    window_sum;
  logic [SUM_W-1:0]    previous_sum;
  logic [SUM_W-1:0]    older_sum;
  logic [INDEX_W-1:0]  sample_counter;
  logic [INDEX_W-1:0]  last_peak_index;
  logic                have_peak;
  logic [COUNT_W-1:0]  peak_total;
  logic [TOTAL_W-1:0]  interval_sum;
  logic [FILL_W-1:0]   fill_count;

  logic [SUM_W-1:0]    window_sum_next;
  logic [FILL_W-1:0]   fill_count_next;
  logic [SUM_W-1:0]    threshold_scaled;
  logic [INDEX_W-1:0]  pidx;
  logic [INDEX_W-1:0]  ivl;
  logic [TOTAL_W:0]    total_wide;
  logic [TOTAL_W-1:0]  interval_sum_next;
  logic [COUNT_W-1:0]  peak_total_next;

  always_comb begin
    // Add the newest sample, drop the one that leaves the window.
    window_sum_next  = window_sum + SUM_W'(in_sample) - SUM_W'(taps[WINDOW-1]);
    fill_count_next  = (fill_count < FILL_W'(FILL_MAX)) ? fill_count + 1'b1 : fill_count;
    threshold_scaled = SUM_W'(peak_threshold) * SUM_W'(WINDOW);

    // The candidate is the sum one sample back; its slopes straddle it.
    hit = (fill_count_next == FILL_W'(FILL_MAX)) &&
          (previous_sum <= window_sum) &&
          (window_sum_next <= window_sum) &&
          (window_sum > threshold_scaled);

    pidx = sample_counter - INDEX_W'(CENTER_OFS);
    ivl  = have_peak ? (pidx - last_peak_index) : '0;

    total_wide = {1'b0, interval_sum} + (TOTAL_W+1)'(ivl);
    interval_sum_next = total_wide[TOTAL_W] ? {TOTAL_W{1'b1}} : total_wide[TOTAL_W-1:0];
    peak_total_next   = (peak_total != {COUNT_W{1'b1}}) ? peak_total + 1'b1 : peak_total;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < WINDOW; k++) begin
        taps[k] <= '0;
      end
      window_sum      <= '0;
      previous_sum    <= '0;
      older_sum       <= '0;
      sample_counter  <= '0;
      last_peak_index <= '0;
      have_peak       <= 1'b0;
      peak_total      <= '0;
      interval_sum    <= '0;
      fill_count      <= '0;
    end else if (advance) begin
      taps[0] <= in_sample;
      for (int k = 1; k < WINDOW; k++) begin
        taps[k] <= taps[k-1];
      end
      window_sum     <= window_sum_next;
      previous_sum   <= window_sum;
      older_sum      <= previous_sum;
      sample_counter <= sample_counter + 1'b1;
      fill_count     <= fill_count_next;
      if (hit) begin
        last_peak_index <= pidx;
        have_peak       <= 1'b1;
        peak_total      <= peak_total_next;
        interval_sum    <= interval_sum_next;
      end
    end
  end

  // -------------------------------------------------------- result register
  logic [INDEX_W-1:0] out_index;
  logic [INDEX_W-1:0] out_interval;
  logic               out_interval_valid;
  logic [COUNT_W-1:0] out_count;
  logic [TOTAL_W-1:0] out_total;
  logic               out_valid_next;

  always_comb begin
    out_valid_next = out_valid && !m_axis_tready;
    if (advance && hit) begin
      out_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && hit) begin
      out_index          <= pidx;
      out_interval       <= ivl;
      out_interval_valid <= have_peak;
      out_count          <= peak_total_next;
      out_total          <= have_peak ? interval_sum_next : interval_sum;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_total, out_count, out_interval, out_index};
  assign m_axis_tuser  = out_interval_valid;

  // -------------------------------------------------------------- checks
  // The running count is one exactly for the first peak, which has no interval.
  a_first_peak_no_interval: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_interval_valid == (out_count != COUNT_W'(1))))
    else $error("interval_valid disagrees with peak count");

  // A peak has been seen exactly when the count is nonzero.
  a_have_peak_count: assert property (@(posedge clk) disable iff (rst)
    have_peak == (peak_total != '0))
    else $error("have_peak out of step with peak_total");

  // Input side backs up only when a result is blocked downstream.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !s_axis_tready) |-> (out_valid && !m_axis_tready))
    else $error("input stalled without a blocked result");

endmodule

`default_nettype wire

// File: tb/sv/ecg_r_peak_detector_unit_tb.sv
// Self-checking testbench for ecg_r_peak_detector_unit: sample stream in, peak beats out.
// Depends on ecgrpd_pkg and the detector RTL. Checks every peak beat against
// an in-bench model of the running-sum slope detector.
module ecg_r_peak_detector_unit_tb
  import ecgrpd_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Idle cycles with no beat on either stream before the run is declared hung.
  localparam int STALL_LIMIT  = 4000;
  // Receiver hold-off length for the backpressure test.
  localparam int HOLD_CYCLES  = 300;
  // Cycles to let an in-flight sample clear both pipeline registers.
  localparam int SETTLE_CYCLES = 8;
  localparam logic [APB_ADDR_W-1:0] THRESHOLD_ADDR = {REG_PEAK_THRESHOLD, 2'b00};

  typedef struct {
    logic [INDEX_W-1:0] idx;
    logic [INDEX_W-1:0] gap;
    logic               gap_ok;
    logic [COUNT_W-1:0] count;
    logic [TOTAL_W-1:0] total;
  } peak_rec_t;

  // Clock, reset and every DUT input start at a known value.
  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               s_valid = 1'b0;
  logic               s_axis_tready;
  logic [SDATA_W-1:0] s_data = '0;
  logic               m_axis_tvalid;
  logic               m_ready = 1'b0;
  logic [MDATA_W-1:0] m_axis_tdata;
  logic               m_axis_tuser;

  // Expected peak beats, oldest first.
  peak_rec_t pending_peaks[$];

  // Detector model state.
  logic [SAMPLE_W-1:0] win_buf [WINDOW];
  int unsigned         wr_pos;
  logic [SUM_W-1:0]    sum_now, sum_prev, sum_old;
  int unsigned         fill;
  logic [INDEX_W-1:0]  next_index;
  logic [INDEX_W-1:0]  last_peak;
  bit                  seen_peak;
  logic [COUNT_W-1:0]  peaks_so_far;
  logic [TOTAL_W-1:0]  gap_total;
  logic [SAMPLE_W-1:0] thr_model;

  // Run bookkeeping.
  int  fail_count = 0;
  int  samples_sent = 0;
  int  peaks_checked = 0;
  int  thresholds_set = 0;
  int  burst_left = 0;
  bit  gaps_on = 1'b1;
  bit  hold_request = 1'b0;

  ecg_r_peak_detector_unit dut (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_data),        // [11:0] sample, [15:12] ignored
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_axis_tdata),  // [31:0] peak_index, [63:32] interval,
                                    // [79:64] peak_count, [127:80] interval_total
    .m_axis_tuser  (m_axis_tuser)   // [0] interval_valid
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Detector model
  // ---------------------------------------------------------------------------

  // Advance the model by one accepted sample; queue a peak beat when the sum
  // one index back is a local maximum above threshold*WINDOW.
  task automatic detect_peak(input logic [SAMPLE_W-1:0] adc);
    int unsigned        acc;
    peak_rec_t          rec;
    logic [TOTAL_W:0]   grown;
    win_buf[wr_pos] = adc;
    wr_pos = (wr_pos + 1) % WINDOW;
    sum_old  = sum_prev;
    sum_prev = sum_now;
    acc = 0;
    for (int k = 0; k < WINDOW; k++) acc += win_buf[k];
    sum_now = SUM_W'(acc);
    // Hold off testing until three real sums exist.
    if (fill < FILL_MAX) fill++;
    if (fill >= FILL_MAX && sum_old <= sum_prev && sum_now <= sum_prev &&
        int'(sum_prev) > int'(thr_model) * WINDOW) begin
      // Report at the window centre of the sum one index back.
      rec.idx    = next_index - INDEX_W'(CENTER_OFS);
      rec.gap    = '0;
      rec.gap_ok = 1'b0;
      if (seen_peak) begin
        rec.gap    = rec.idx - last_peak;
        rec.gap_ok = 1'b1;
        grown = {1'b0, gap_total} + (TOTAL_W+1)'(rec.gap);
        gap_total = grown[TOTAL_W] ? '1 : grown[TOTAL_W-1:0];
      end
      if (peaks_so_far != '1) peaks_so_far++;
      last_peak = rec.idx;
      seen_peak = 1'b1;
      rec.count = peaks_so_far;
      rec.total = gap_total;
      pending_peaks.push_back(rec);
    end
    next_index++;
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Offer one sample, with random junk in the unused upper tdata bits, and
  // wait for its beat. While gaps are on, insert a random gap whenever the current burst runs out.
  task automatic send_sample(input logic [SAMPLE_W-1:0] adc);
    if (gaps_on && burst_left == 0) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 40);
    end
    s_valid <= 1'b1;
    s_data  <= {(SDATA_W-SAMPLE_W)'($urandom_range(0, 15)), adc};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (burst_left > 0) burst_left--;
    samples_sent++;
    detect_peak(adc);
  endtask

  // Drop valid, wait for every expected peak, then let the pipeline empty.
  task automatic drain_and_settle();
    s_valid <= 1'b0;
    while (pending_peaks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One APB transfer: setup cycle, then access cycle until pready.
  task automatic apb_transfer(input bit is_write, input logic [31:0] wdata,
                              output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= THRESHOLD_ADDR;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Write the threshold once idle, with random upper pwdata bits, and read it back.
  task automatic set_threshold(input logic [SAMPLE_W-1:0] level);
    logic [31:0] word;
    logic [31:0] rd;
    drain_and_settle();
    word = {20'($urandom()), level};
    apb_transfer(1'b1, word, rd);
    thr_model = level;
    thresholds_set++;
    @(posedge clk);
    apb_transfer(1'b0, '0, rd);
    if (rd !== {20'b0, level}) begin
      $display("%0t: threshold readback expected %0h actual %0h", $realtime, level, rd);
      fail_count++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Read the threshold straight out of reset.
  task automatic test_reset_threshold();
    logic [31:0] rd;
    apb_transfer(1'b0, '0, rd);
    if (rd !== {20'b0, THRESHOLD_RESET}) begin
      $display("%0t: reset threshold expected %0h actual %0h",
               $realtime, THRESHOLD_RESET, rd);
      fail_count++;
    end
  endtask

  // Full-scale ramp whose maximum falls before the three sums exist, so it
  // must be suppressed; then a clean first peak with no previous interval.
  task automatic test_stream_start();
    logic [SAMPLE_W-1:0] shape [11] = '{12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF,
                                        12'h000, 12'h000, 12'd2000, 12'hFFF,
                                        12'd2000, 12'h000};
    foreach (shape[i]) send_sample(shape[i]);
  endtask

  // Threshold zero: an all-zero window never fires, a plateau of sum one does.
  // Threshold 4095: a full-scale plateau sits exactly on threshold*WINDOW and
  // must not fire.
  task automatic test_threshold_extremes();
    logic [SAMPLE_W-1:0] low_shape [7] = '{12'd0, 12'd0, 12'd0, 12'd0, 12'd1,
                                          12'd0, 12'd0};
    set_threshold('0);
    foreach (low_shape[i]) send_sample(low_shape[i]);
    set_threshold('1);
    repeat (6) send_sample('1);
  endtask

  // Hold the receiver off for a long stretch while alternating full-scale
  // samples make a peak every other beat, so the block backs up and drops
  // s_axis_tready.
  task automatic test_output_backpressure();
    set_threshold('0);
    gaps_on = 1'b0;
    hold_request = 1'b1;
    for (int i = 0; i < 60; i++) send_sample(i[0] ? '1 : '0);
    drain_and_settle();
    while (hold_request) @(posedge clk);
    gaps_on = 1'b1;
  endtask

  // One threshold setting, then a stream that is mostly heartbeat-like
  // (baseline, noise and periodic spikes), with uniform noise and
  // full-scale square runs mixed in.
  task automatic run_random_phase(input int n_items, input logic [SAMPLE_W-1:0] level);
    int mode, run_left, base, period, pos, amp, ramp, v;
    set_threshold(level);
    run_left = 0;
    mode = 0; base = 0; period = 12; pos = 0; amp = 0;
    for (int i = 0; i < n_items; i++) begin
      if (run_left == 0) begin
        mode     = $urandom_range(0, 9);
        run_left = $urandom_range(20, 120);
        base     = $urandom_range(100, 1500);
        period   = $urandom_range(12, 60);
        amp      = $urandom_range(500, 4095);
        pos      = $urandom_range(0, period - 1);
      end
      if (mode <= 6) begin
        ramp = (pos <= 3) ? pos : ((pos < 7) ? 6 - pos : 0);
        v = base + amp * ramp / 3 + int'($urandom_range(0, 60)) - 30;
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
        pos = (pos + 1) % period;
      end else if (mode <= 8) begin
        v = $urandom_range(0, 4095);
      end else begin
        v = ((i / 4) % 2) ? 4095 : 0;
      end
      send_sample(SAMPLE_W'(v));
      run_left--;
    end
  endtask

  task automatic test_random_stream();
    run_random_phase(350, SAMPLE_W'($urandom_range(300, 1500)));
    run_random_phase(250, '0);
    run_random_phase(80, '1);
    run_random_phase(300, SAMPLE_W'($urandom_range(0, 4095)));
    run_random_phase(350, SAMPLE_W'($urandom_range(600, 1200)));
    run_random_phase(250, 12'd1);
    run_random_phase(180, SAMPLE_W'($urandom_range(200, 900)));
  endtask

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------

  initial begin : sequencer
    // Model mirrors the reset state of the block.
    foreach (win_buf[i]) win_buf[i] = '0;
    wr_pos = 0;
    sum_now = '0; sum_prev = '0; sum_old = '0;
    fill = 0;
    next_index = '0;
    last_peak = '0;
    seen_peak = 1'b0;
    peaks_so_far = '0;
    gap_total = '0;
    thr_model = THRESHOLD_RESET;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_threshold();
    test_stream_start();
    test_threshold_extremes();
    test_output_backpressure();
    test_random_stream();

    // Wait out every expected beat plus the pipeline depth; the watchdog
    // bounds this wait.
    drain_and_settle();

    $display("Sent %0d samples and checked %0d peak beats over %0d threshold writes,",
             samples_sent, peaks_checked, thresholds_set);
    $display("with bursty input, random output stalls and one long output hold-off.");
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver stall pattern
  // ---------------------------------------------------------------------------

  // Pick a stall density per stretch, from none to heavy; honor a hold-off
  // request by holding tready low for HOLD_CYCLES, then release it.
  initial begin : sink_pattern
    int stall_pct, span;
    forever begin
      if (hold_request) begin
        m_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end else begin
        span = $urandom_range(8, 64);
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 25;
          2: stall_pct = 60;
          default: stall_pct = 90;
        endcase
        while (span > 0 && !hold_request) begin
          m_ready <= ($urandom_range(0, 99) >= stall_pct);
          @(posedge clk);
          span--;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Peak beat checker
  // ---------------------------------------------------------------------------

  task automatic check_field(input string name, input int beat_no,
                             input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: peak beat %0d %s expected %0h actual %0h",
               $realtime, beat_no, name, want, got);
      fail_count++;
    end
  endtask

  // Compare each accepted peak beat with the oldest expectation.
  always @(posedge clk) begin : peak_check
    peak_rec_t want;
    if (!rst && m_axis_tvalid && m_ready) begin
      if (pending_peaks.size() == 0) begin
        $display("%0t: unexpected peak beat, expected none actual index %0h",
                 $realtime, m_axis_tdata[31:0]);
        fail_count++;
      end else begin
        want = pending_peaks.pop_front();
        check_field("peak_index", peaks_checked, want.idx, m_axis_tdata[31:0]);
        check_field("interval", peaks_checked, want.gap, m_axis_tdata[63:32]);
        check_field("interval_valid", peaks_checked, want.gap_ok, m_axis_tuser);
        check_field("peak_count", peaks_checked, want.count, m_axis_tdata[79:64]);
        check_field("interval_total", peaks_checked, want.total, m_axis_tdata[127:80]);
      end
      peaks_checked++;
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog
  // ---------------------------------------------------------------------------

  // Count cycles with no beat on either stream; a long run of them means a hang.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (s_valid && s_axis_tready) || (m_axis_tvalid && m_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("%0t: no beat for %0d cycles, %0d peak beats still expected",
             $realtime, STALL_LIMIT, pending_peaks.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
